// ===== rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants and types for the segment pair intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

    // default sizes of the coordinate inputs and of the fixed point fraction
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // width of every result coordinate
    localparam int OUT_BITS = 32;

    typedef logic [1:0] outcome_t;

    // outcome codes
    localparam outcome_t OUTC_NONE    = 2'd0;
    localparam outcome_t OUTC_POINT   = 2'd1;
    localparam outcome_t OUTC_SEGMENT = 2'd2;

endpackage

// ===== rtl/segment_pair_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_pair_intersection
// Intersects two 2D segments ab and cd with exact integer sign tests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one segment pair per transaction (valid/ready).
//   m_* channel returns one result per pair: outcome, point p and, for a
//   shared segment, point q, in signed fixed point with FRAC_BITS fraction
//   bits; unused points read zero.
//   cfg_* channel writes touch_counts (1: end point contact counts).
//   Only write it while no pair is in flight.
// Timing:
//   One pair per cycle is sustained while the skid register is empty.
//   The pipe holds a restoring divider, one quotient bit per stage,
//   behind five stages of subtract, multiply, add, classify and multiply.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline, the output
//   register and the skid register, and sets touch_counts to 1.
// Stall:
//   When m_ready is low the result holds; one further result lands in the
//   skid register and only then does s_ready fall and the pipeline freeze.
// ----------------------------------------------------------------------------
module segment_pair_intersection #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    // segment pair input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_a_x,
    input  logic signed [COORD_BITS-1:0]  s_a_y,
    input  logic signed [COORD_BITS-1:0]  s_b_x,
    input  logic signed [COORD_BITS-1:0]  s_b_y,
    input  logic signed [COORD_BITS-1:0]  s_c_x,
    input  logic signed [COORD_BITS-1:0]  s_c_y,
    input  logic signed [COORD_BITS-1:0]  s_d_x,
    input  logic signed [COORD_BITS-1:0]  s_d_y,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output spi_pkg::outcome_t             m_outcome,
    output logic signed [spi_pkg::OUT_BITS-1:0] m_p_x,
    output logic signed [spi_pkg::OUT_BITS-1:0] m_p_y,
    output logic signed [spi_pkg::OUT_BITS-1:0] m_q_x,
    output logic signed [spi_pkg::OUT_BITS-1:0] m_q_y
);
    import spi_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int OW   = OUT_BITS;
    localparam int DFW  = C + 1;                 // coordinate difference
    localparam int PW   = 2 * DFW;               // product of two differences
    localparam int SW   = PW + 2;                // cross and dot sums
    localparam int DENW = SW;                    // divisor magnitude
    localparam int MW   = SW + C;                // dividend magnitude
    localparam int QB   = C + F;                 // quotient bits
    localparam int XW   = (QB + 1 > OW) ? QB + 1 : OW;
    localparam int NST  = QB + 6;                // pipeline stages

    typedef struct packed {
        outcome_t             outcome;
        logic                 crossing;
        logic signed [C-1:0]  px;
        logic signed [C-1:0]  py;
        logic signed [C-1:0]  qx;
        logic signed [C-1:0]  qy;
    } tail_t;

    typedef struct packed {
        tail_t                tl;
        logic [DENW-1:0]      den;
        logic                 negx;
        logic                 negy;
        logic [MW-1:0]        mx;
        logic [MW-1:0]        my;
        logic [DENW-1:0]      remx;
        logic [DENW-1:0]      remy;
        logic [QB-1:0]        qtx;
        logic [QB-1:0]        qty;
    } div_t;

    typedef struct packed {
        outcome_t             outcome;
        logic signed [OW-1:0] p_x;
        logic signed [OW-1:0] p_y;
        logic signed [OW-1:0] q_x;
        logic signed [OW-1:0] q_y;
    } res_t;

    // lexicographic a < b, x first
    function automatic logic lex_lt(input logic signed [C-1:0] ax,
                                    input logic signed [C-1:0] ay,
                                    input logic signed [C-1:0] bx,
                                    input logic signed [C-1:0] by);
        lex_lt = (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic touch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            touch_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: whole pipe advances while the skid is empty
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic           skid_full_reg;
    logic           en;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 0: coordinate differences
    // ------------------------------------------------------------------
    logic signed [DFW-1:0] s0_abx_reg, s0_aby_reg, s0_acx_reg, s0_acy_reg;
    logic signed [DFW-1:0] s0_cdx_reg, s0_cdy_reg;
    logic signed [C-1:0]   s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg;
    logic signed [C-1:0]   s0_cx_reg, s0_cy_reg, s0_dx_reg, s0_dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_abx_reg <= DFW'(s_b_x) - DFW'(s_a_x);
            s0_aby_reg <= DFW'(s_b_y) - DFW'(s_a_y);
            s0_acx_reg <= DFW'(s_c_x) - DFW'(s_a_x);
            s0_acy_reg <= DFW'(s_c_y) - DFW'(s_a_y);
            s0_cdx_reg <= DFW'(s_d_x) - DFW'(s_c_x);
            s0_cdy_reg <= DFW'(s_d_y) - DFW'(s_c_y);
            s0_ax_reg  <= s_a_x;
            s0_ay_reg  <= s_a_y;
            s0_bx_reg  <= s_b_x;
            s0_by_reg  <= s_b_y;
            s0_cx_reg  <= s_c_x;
            s0_cy_reg  <= s_c_y;
            s0_dx_reg  <= s_d_x;
            s0_dy_reg  <= s_d_y;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: products, ordered end points of each segment
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s1_abx_cdy_reg, s1_aby_cdx_reg;   // cross(ab, cd)
    logic signed [PW-1:0] s1_acx_aby_reg, s1_acy_abx_reg;   // cross(ac, ab)
    logic signed [PW-1:0] s1_acx_cdy_reg, s1_acy_cdx_reg;   // cross(ac, cd)
    logic signed [PW-1:0] s1_abx_abx_reg, s1_aby_aby_reg;   // |ab|^2
    logic signed [PW-1:0] s1_acx_abx_reg, s1_acy_aby_reg;   // dot(ac, ab)
    logic signed [PW-1:0] s1_cdx_abx_reg, s1_cdy_aby_reg;   // dot(cd, ab)
    logic signed [C-1:0]  s1_m1x_reg, s1_m1y_reg, s1_m2x_reg, s1_m2y_reg;
    logic signed [C-1:0]  s1_r1x_reg, s1_r1y_reg, s1_r2x_reg, s1_r2y_reg;
    logic signed [C-1:0]  s1_ax_reg, s1_ay_reg;
    logic signed [DFW-1:0] s1_abx_reg, s1_aby_reg;
    logic                 s1_b_lt_a, s1_d_lt_c;

    assign s1_b_lt_a = lex_lt(s0_bx_reg, s0_by_reg, s0_ax_reg, s0_ay_reg);
    assign s1_d_lt_c = lex_lt(s0_dx_reg, s0_dy_reg, s0_cx_reg, s0_cy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_abx_cdy_reg <= s0_abx_reg * s0_cdy_reg;
            s1_aby_cdx_reg <= s0_aby_reg * s0_cdx_reg;
            s1_acx_aby_reg <= s0_acx_reg * s0_aby_reg;
            s1_acy_abx_reg <= s0_acy_reg * s0_abx_reg;
            s1_acx_cdy_reg <= s0_acx_reg * s0_cdy_reg;
            s1_acy_cdx_reg <= s0_acy_reg * s0_cdx_reg;
            s1_abx_abx_reg <= s0_abx_reg * s0_abx_reg;
            s1_aby_aby_reg <= s0_aby_reg * s0_aby_reg;
            s1_acx_abx_reg <= s0_acx_reg * s0_abx_reg;
            s1_acy_aby_reg <= s0_acy_reg * s0_aby_reg;
            s1_cdx_abx_reg <= s0_cdx_reg * s0_abx_reg;
            s1_cdy_aby_reg <= s0_cdy_reg * s0_aby_reg;
            s1_m1x_reg     <= s1_b_lt_a ? s0_bx_reg : s0_ax_reg;
            s1_m1y_reg     <= s1_b_lt_a ? s0_by_reg : s0_ay_reg;
            s1_m2x_reg     <= s1_b_lt_a ? s0_ax_reg : s0_bx_reg;
            s1_m2y_reg     <= s1_b_lt_a ? s0_ay_reg : s0_by_reg;
            s1_r1x_reg     <= s1_d_lt_c ? s0_dx_reg : s0_cx_reg;
            s1_r1y_reg     <= s1_d_lt_c ? s0_dy_reg : s0_cy_reg;
            s1_r2x_reg     <= s1_d_lt_c ? s0_cx_reg : s0_dx_reg;
            s1_r2y_reg     <= s1_d_lt_c ? s0_cy_reg : s0_dy_reg;
            s1_ax_reg      <= s0_ax_reg;
            s1_ay_reg      <= s0_ay_reg;
            s1_abx_reg     <= s0_abx_reg;
            s1_aby_reg     <= s0_aby_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cross and dot sums, overlap end points
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s2_c1_reg, s2_c2_reg, s2_tn_reg;
    logic signed [SW-1:0] s2_sq_reg, s2_t0_reg, s2_t1_reg;
    logic signed [C-1:0]  s2_px_reg, s2_py_reg, s2_qx_reg, s2_qy_reg;
    logic signed [C-1:0]  s2_ax_reg, s2_ay_reg;
    logic signed [DFW-1:0] s2_abx_reg, s2_aby_reg;
    logic signed [SW-1:0] s2_t0, s2_dot;
    logic                 s2_m1_lt_r1, s2_r2_lt_m2;

    assign s2_t0  = SW'(s1_acx_abx_reg) + SW'(s1_acy_aby_reg);
    assign s2_dot = SW'(s1_cdx_abx_reg) + SW'(s1_cdy_aby_reg);
    assign s2_m1_lt_r1 = lex_lt(s1_m1x_reg, s1_m1y_reg, s1_r1x_reg, s1_r1y_reg);
    assign s2_r2_lt_m2 = lex_lt(s1_r2x_reg, s1_r2y_reg, s1_m2x_reg, s1_m2y_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_c1_reg  <= SW'(s1_abx_cdy_reg) - SW'(s1_aby_cdx_reg);
            s2_c2_reg  <= SW'(s1_acx_aby_reg) - SW'(s1_acy_abx_reg);
            s2_tn_reg  <= SW'(s1_acx_cdy_reg) - SW'(s1_acy_cdx_reg);
            s2_sq_reg  <= SW'(s1_abx_abx_reg) + SW'(s1_aby_aby_reg);
            s2_t0_reg  <= s2_t0;
            s2_t1_reg  <= s2_t0 + s2_dot;
            // later of the two lower ends, earlier of the two upper ends
            s2_px_reg  <= s2_m1_lt_r1 ? s1_r1x_reg : s1_m1x_reg;
            s2_py_reg  <= s2_m1_lt_r1 ? s1_r1y_reg : s1_m1y_reg;
            s2_qx_reg  <= s2_r2_lt_m2 ? s1_r2x_reg : s1_m2x_reg;
            s2_qy_reg  <= s2_r2_lt_m2 ? s1_r2y_reg : s1_m2y_reg;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_abx_reg <= s1_abx_reg;
            s2_aby_reg <= s1_aby_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: classify, normalise divisor sign
    // ------------------------------------------------------------------
    logic                 s3_coll, s3_hit, s3_c1neg, s3_tin, s3_uin, s3_same;
    logic signed [SW-1:0] s3_lo, s3_hi, s3_den, s3_tn, s3_un;
    logic signed [DFW-1:0] s3_absx, s3_absy;
    outcome_t             s3_outcome;
    tail_t                s3_tail;

    tail_t                s3_tail_reg;
    logic [DENW-1:0]      s3_den_reg;
    logic [SW-1:0]        s3_tn_reg;
    logic [C-1:0]         s3_absx_reg, s3_absy_reg;
    logic                 s3_negx_reg, s3_negy_reg;

    always_comb begin
        s3_coll  = (s2_c1_reg == '0) && (s2_c2_reg == '0);
        s3_lo    = (s2_t0_reg < s2_t1_reg) ? s2_t0_reg : s2_t1_reg;
        s3_hi    = (s2_t0_reg < s2_t1_reg) ? s2_t1_reg : s2_t0_reg;
        s3_hit   = touch_reg ? (s3_lo <= s2_sq_reg && s3_hi >= 0)
                             : (s3_lo <  s2_sq_reg && s3_hi >  0);
        s3_c1neg = s2_c1_reg < 0;
        s3_den   = s3_c1neg ? -s2_c1_reg : s2_c1_reg;
        s3_tn    = s3_c1neg ? -s2_tn_reg : s2_tn_reg;
        s3_un    = s3_c1neg ? -s2_c2_reg : s2_c2_reg;
        s3_tin   = touch_reg ? (s3_tn >= 0 && s3_tn <= s3_den)
                             : (s3_tn >  0 && s3_tn <  s3_den);
        s3_uin   = touch_reg ? (s3_un >= 0 && s3_un <= s3_den)
                             : (s3_un >  0 && s3_un <  s3_den);
        s3_same  = (s2_px_reg == s2_qx_reg) && (s2_py_reg == s2_qy_reg);
        s3_absx  = (s2_abx_reg < 0) ? -s2_abx_reg : s2_abx_reg;
        s3_absy  = (s2_aby_reg < 0) ? -s2_aby_reg : s2_aby_reg;

        if (s3_coll) begin
            // zero length ab never meets in the collinear case
            if (s2_sq_reg == '0 || !s3_hit) begin
                s3_outcome = OUTC_NONE;
            end else if (s3_same) begin
                s3_outcome = OUTC_POINT;
            end else begin
                s3_outcome = OUTC_SEGMENT;
            end
        end else if (s2_c1_reg == '0) begin
            s3_outcome = OUTC_NONE;                // parallel, distinct lines
        end else if (s3_tin && s3_uin) begin
            s3_outcome = OUTC_POINT;
        end else begin
            s3_outcome = OUTC_NONE;
        end

        s3_tail.outcome  = s3_outcome;
        s3_tail.crossing = !s3_coll;
        s3_tail.px       = s3_coll ? s2_px_reg : s2_ax_reg;
        s3_tail.py       = s3_coll ? s2_py_reg : s2_ay_reg;
        s3_tail.qx       = s2_qx_reg;
        s3_tail.qy       = s2_qy_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_tail_reg <= s3_tail;
            s3_den_reg  <= DENW'(s3_den);
            s3_tn_reg   <= s3_tn;
            s3_absx_reg <= s3_absx[C-1:0];
            s3_absy_reg <= s3_absy[C-1:0];
            s3_negx_reg <= s2_abx_reg < 0;
            s3_negy_reg <= s2_aby_reg < 0;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: dividend magnitudes t_num * |ab|
    // ------------------------------------------------------------------
    tail_t           s4_tail_reg;
    logic [DENW-1:0] s4_den_reg;
    logic [MW-1:0]   s4_mx_reg, s4_my_reg;
    logic            s4_negx_reg, s4_negy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_tail_reg <= s3_tail_reg;
            s4_den_reg  <= s3_den_reg;
            s4_mx_reg   <= MW'(s3_tn_reg) * MW'(s3_absx_reg);
            s4_my_reg   <= MW'(s3_tn_reg) * MW'(s3_absy_reg);
            s4_negx_reg <= s3_negx_reg;
            s4_negy_reg <= s3_negy_reg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit of (M << F) / den per stage
    // ------------------------------------------------------------------
    div_t dv_reg [QB];
    div_t dv_src [QB];

    // quotient fits QB bits, so the top part of the dividend is below den
    assign dv_src[0] = '{tl:   s4_tail_reg,
                         den:  s4_den_reg,
                         negx: s4_negx_reg,
                         negy: s4_negy_reg,
                         mx:   s4_mx_reg,
                         my:   s4_my_reg,
                         remx: DENW'(s4_mx_reg >> C),
                         remy: DENW'(s4_my_reg >> C),
                         qtx:  '0,
                         qty:  '0};

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic            nbx, nby;
        logic [DENW:0]   r2x, r2y, dx_diff, dy_diff;
        div_t            dnext;

        if (j > 0) begin : g_src
            assign dv_src[j] = dv_reg[j-1];
        end

        // dividend bit entering this step; fraction positions are zero
        if (QB - 1 - j >= F) begin : g_nbit
            assign nbx = dv_src[j].mx[QB-1-j-F];
            assign nby = dv_src[j].my[QB-1-j-F];
        end else begin : g_zbit
            assign nbx = 1'b0;
            assign nby = 1'b0;
        end

        always_comb begin
            dnext   = dv_src[j];
            r2x     = {dv_src[j].remx, nbx};
            r2y     = {dv_src[j].remy, nby};
            dx_diff = r2x - {1'b0, dv_src[j].den};
            dy_diff = r2y - {1'b0, dv_src[j].den};
            if (r2x >= {1'b0, dv_src[j].den}) begin
                dnext.remx           = dx_diff[DENW-1:0];
                dnext.qtx[QB-1-j]    = 1'b1;
            end else begin
                dnext.remx           = r2x[DENW-1:0];
            end
            if (r2y >= {1'b0, dv_src[j].den}) begin
                dnext.remy           = dy_diff[DENW-1:0];
                dnext.qty[QB-1-j]    = 1'b1;
            end else begin
                dnext.remy           = r2y[DENW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[j] <= dnext;
            end
        end
    end

    // ------------------------------------------------------------------
    // final stage: floor for negative direction, add base, fixed point
    // ------------------------------------------------------------------
    div_t              fn;
    logic [XW-1:0]     fn_qx, fn_qy, fn_vx, fn_vy;
    logic [XW-1:0]     fn_px, fn_py, fn_qpx, fn_qpy;
    logic [XW-1:0]     fn_sumx, fn_sumy;
    res_t              fn_res;
    res_t              fin_reg;

    assign fn = dv_reg[QB-1];

    always_comb begin
        fn_qx   = XW'(fn.qtx);
        fn_qy   = XW'(fn.qty);
        fn_vx   = fn.negx ? (-fn_qx - XW'(fn.remx != '0)) : fn_qx;
        fn_vy   = fn.negy ? (-fn_qy - XW'(fn.remy != '0)) : fn_qy;
        fn_px   = XW'(fn.tl.px) << F;
        fn_py   = XW'(fn.tl.py) << F;
        fn_qpx  = XW'(fn.tl.qx) << F;
        fn_qpy  = XW'(fn.tl.qy) << F;
        fn_sumx = fn_px + (fn.tl.crossing ? fn_vx : '0);
        fn_sumy = fn_py + (fn.tl.crossing ? fn_vy : '0);

        fn_res.outcome = fn.tl.outcome;
        fn_res.p_x     = '0;
        fn_res.p_y     = '0;
        fn_res.q_x     = '0;
        fn_res.q_y     = '0;
        if (fn.tl.outcome != OUTC_NONE) begin
            fn_res.p_x = fn_sumx[OW-1:0];
            fn_res.p_y = fn_sumy[OW-1:0];
        end
        if (fn.tl.outcome == OUTC_SEGMENT) begin
            fn_res.q_x = fn_qpx[OW-1:0];
            fn_res.q_y = fn_qpy[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fn_res;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid register
    // ------------------------------------------------------------------
    res_t out_reg, skid_reg;
    logic out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg <= vld_reg[NST-1];
        end else if (vld_reg[NST-1]) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_reg <= fin_reg;
        end else begin
            skid_reg <= fin_reg;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_outcome = out_reg.outcome;
    assign m_p_x     = out_reg.p_x;
    assign m_p_y     = out_reg.p_y;
    assign m_q_x     = out_reg.q_x;
    assign m_q_y     = out_reg.q_y;

`ifndef SYNTH
    // no meeting leaves every point zero
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUTC_NONE
        |-> m_p_x == '0 && m_p_y == '0 && m_q_x == '0 && m_q_y == '0)
        else $error("non-zero point on a miss");

    // a single point leaves q zero
    a_point_q_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUTC_POINT |-> m_q_x == '0 && m_q_y == '0)
        else $error("q set on a single point result");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty after reset");

    // input is refused only while a result waits untaken
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("input stalled without an output stall");
`endif

endmodule

// ===== dv/tb_segment_pair_intersection.sv =====
// ----------------------------------------------------------------------------
// tb_segment_pair_intersection
// Self-checking bench for the segment pair intersection block: directed
// corner pairs under both touch settings, then constructed and random pairs
// under varying input and output back-pressure, each checked field by field
// against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_segment_pair_intersection;
    import spi_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = CB + FB + 7;

    typedef logic signed [CB-1:0]       coord_t;
    typedef logic signed [OUT_BITS-1:0] fix_t;

    typedef struct {
        outcome_t oc;
        fix_t     px, py, qx, qy;
    } meeting_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   cfg_valid = 1'b0, cfg_data = 1'b0;
    logic   cfg_ready;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_a_x = '0, s_a_y = '0, s_b_x = '0, s_b_y = '0;
    coord_t s_c_x = '0, s_c_y = '0, s_d_x = '0, s_d_y = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    outcome_t m_outcome;
    fix_t   m_p_x, m_p_y, m_q_x, m_q_y;

    meeting_t meetings_due[$];
    bit       touch_mode = 1'b1;
    int       send_idle_pct = 0, recv_idle_pct = 0;
    int       errors = 0;

    segment_pair_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_b_x(s_b_x), .s_b_y(s_b_y),
        .s_c_x(s_c_x), .s_c_y(s_c_y), .s_d_x(s_d_x), .s_d_y(s_d_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_outcome(m_outcome),
        .m_p_x(m_p_x), .m_p_y(m_p_y), .m_q_x(m_q_x), .m_q_y(m_q_y)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(12 * 600000);
        $display("status: fail");
        $finish;
    end

    // ---------------- prediction ----------------
    function automatic int lex_order(longint ax, longint ay, longint bx, longint by);
        if (ax != bx) return (ax < bx) ? -1 : 1;
        if (ay != by) return (ay < by) ? -1 : 1;
        return 0;
    endfunction

    function automatic fix_t int_to_fix(longint v);
        longint w;
        w = v <<< FB;
        return fix_t'(w);
    endfunction

    // floor(base + num*d/den) in fixed point, den > 0
    function automatic fix_t crossing_coord(longint base, longint num, longint d,
                                            longint den);
        longint x, q, r, f, w;
        x = num * d;
        q = x / den;
        r = x % den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        f = (r <<< FB) / den;
        w = (base <<< FB) + (q <<< FB) + f;
        return fix_t'(w);
    endfunction

    function automatic meeting_t predict_meeting(coord_t iax, iay, ibx, iby,
                                                 icx, icy, idx, idy, bit touch);
        meeting_t res;
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint abx, aby, acx, acy, cdx, cdy, c1, c2, sq, t0, t1, lo, hi;
        longint m1x, m1y, m2x, m2y, r1x, r1y, r2x, r2y, tn, un, den;
        bit hit, t_in, u_in;
        res = '{OUTC_NONE, '0, '0, '0, '0};
        ax = iax; ay = iay; bx = ibx; by = iby;
        cx = icx; cy = icy; dx = idx; dy = idy;
        abx = bx - ax; aby = by - ay;
        acx = cx - ax; acy = cy - ay;
        cdx = dx - cx; cdy = dy - cy;
        c1 = abx * cdy - aby * cdx;
        c2 = acx * aby - acy * abx;
        if (c1 == 0 && c2 == 0) begin
            // collinear: project cd onto ab
            sq = abx * abx + aby * aby;
            if (sq == 0) return res;
            t0 = acx * abx + acy * aby;
            t1 = t0 + cdx * abx + cdy * aby;
            lo = (t0 < t1) ? t0 : t1;
            hi = (t0 < t1) ? t1 : t0;
            hit = touch ? (lo <= sq && hi >= 0) : (lo < sq && hi > 0);
            if (!hit) return res;
            if (lex_order(ax, ay, bx, by) <= 0) begin
                m1x = ax; m1y = ay; m2x = bx; m2y = by;
            end else begin
                m1x = bx; m1y = by; m2x = ax; m2y = ay;
            end
            if (lex_order(cx, cy, dx, dy) <= 0) begin
                r1x = cx; r1y = cy; r2x = dx; r2y = dy;
            end else begin
                r1x = dx; r1y = dy; r2x = cx; r2y = cy;
            end
            if (lex_order(r1x, r1y, m1x, m1y) > 0) begin
                m1x = r1x; m1y = r1y;
            end
            if (lex_order(r2x, r2y, m2x, m2y) < 0) begin
                m2x = r2x; m2y = r2y;
            end
            res.px = int_to_fix(m1x);
            res.py = int_to_fix(m1y);
            if (lex_order(m1x, m1y, m2x, m2y) == 0) begin
                res.oc = OUTC_POINT;
            end else begin
                res.oc = OUTC_SEGMENT;
                res.qx = int_to_fix(m2x);
                res.qy = int_to_fix(m2y);
            end
            return res;
        end
        // parallel distinct lines
        if (c1 == 0) return res;
        tn = acx * cdy - acy * cdx;
        un = c2;
        den = c1;
        if (den < 0) begin
            den = -den; tn = -tn; un = -un;
        end
        t_in = touch ? (tn >= 0 && tn <= den) : (tn > 0 && tn < den);
        u_in = touch ? (un >= 0 && un <= den) : (un > 0 && un < den);
        if (!(t_in && u_in)) return res;
        res.oc = OUTC_POINT;
        res.px = crossing_coord(ax, tn, abx, den);
        res.py = crossing_coord(ay, tn, aby, den);
        return res;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        meeting_t want;
        if (aresetn && m_valid && m_ready) begin
            if (meetings_due.size() == 0) begin
                report_mismatch("unexpected result, outcome", m_outcome, -1);
            end else begin
                want = meetings_due.pop_front();
                if (m_outcome !== want.oc) report_mismatch("outcome", m_outcome, want.oc);
                if (m_p_x !== want.px) report_mismatch("p_x", m_p_x, want.px);
                if (m_p_y !== want.py) report_mismatch("p_y", m_p_y, want.py);
                if (m_q_x !== want.qx) report_mismatch("q_x", m_q_x, want.qx);
                if (m_q_y !== want.qy) report_mismatch("q_y", m_q_y, want.qy);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_pair(coord_t ax, ay, bx, by, cx, cy, dx, dy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_a_x <= ax; s_a_y <= ay; s_b_x <= bx; s_b_y <= by;
        s_c_x <= cx; s_c_y <= cy; s_d_x <= dx; s_d_y <= dy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        meetings_due.push_back(predict_meeting(ax, ay, bx, by, cx, cy, dx, dy,
                                               touch_mode));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (meetings_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_touch(bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        touch_mode = v;
    endtask

    task automatic test_directed;
        // interior crossing with a fractional point
        send_pair(0, 0, 3, 1, 1, -2, 2, 5);
        send_pair(-7, 3, 5, -4, -6, -5, 4, 6);
        // full-range diagonals crossing at the centre
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        // end point contact, T junction and shared end point
        send_pair(0, 0, 4, 0, 2, 0, 2, 5);
        send_pair(0, 0, 4, 4, 4, 4, 9, -1);
        // no contact
        send_pair(0, 0, 1, 1, 5, 0, 6, -3);
        // parallel distinct lines
        send_pair(0, 0, 4, 2, 0, 1, 4, 3);
        // degenerate first segment, on the second and on a degenerate second
        send_pair(3, 3, 3, 3, 0, 0, 6, 6);
        send_pair(3, 3, 3, 3, 3, 3, 3, 3);
        // collinear: overlap, containment, end point touch, disjoint, identical
        send_pair(0, 0, 6, 0, 3, 0, 9, 0);
        send_pair(0, 0, 10, 5, 8, 4, 2, 1);
        send_pair(-2, -2, 2, 2, 2, 2, 5, 5);
        send_pair(0, 0, 2, 0, 3, 0, 7, 0);
        send_pair(0, 5, 0, -5, 0, 5, 0, -5);
        // collinear, degenerate second segment inside
        send_pair(0, 0, 0, 8, 0, 3, 0, 3);
        // collinear at full range
        send_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
        send_pair(-32768, -32768, -32768, 32767, -32768, 0, -32768, 32767);
        drain();
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(5))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return coord_t'($urandom_range(16) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic random_pair;
        int bx0, by0, ux, uy, ka, kb, kc, kd;
        coord_t v[8];
        case ($urandom_range(9))
            0, 1: begin
                foreach (v[i]) v[i] = coord_t'($urandom);
            end
            2: begin
                foreach (v[i]) v[i] = any_coord();
            end
            3, 4: begin
                foreach (v[i]) v[i] = coord_t'($urandom_range(12) - 6);
            end
            5, 6: begin
                // collinear points on one line
                bx0 = $urandom_range(40000) - 20000;
                by0 = $urandom_range(40000) - 20000;
                ux = $urandom_range(100) - 50;
                uy = $urandom_range(100) - 50;
                ka = $urandom_range(20) - 10; kb = $urandom_range(20) - 10;
                kc = $urandom_range(20) - 10; kd = $urandom_range(20) - 10;
                v = '{coord_t'(bx0 + ka * ux), coord_t'(by0 + ka * uy),
                      coord_t'(bx0 + kb * ux), coord_t'(by0 + kb * uy),
                      coord_t'(bx0 + kc * ux), coord_t'(by0 + kc * uy),
                      coord_t'(bx0 + kd * ux), coord_t'(by0 + kd * uy)};
            end
            7: begin
                // shared end point
                foreach (v[i]) v[i] = coord_t'($urandom);
                if ($urandom_range(1)) begin
                    v[4] = v[2]; v[5] = v[3];
                end else begin
                    v[6] = v[0]; v[7] = v[1];
                end
            end
            default: begin
                // segments straddling the origin, likely to cross
                v = '{coord_t'(-$urandom_range(32768)), coord_t'($urandom),
                      coord_t'($urandom_range(32767)), coord_t'($urandom),
                      coord_t'($urandom), coord_t'(-$urandom_range(32768)),
                      coord_t'($urandom), coord_t'($urandom_range(32767))};
            end
        endcase
        send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    task automatic test_random(int n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n) random_pair();
        drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();            // touch_counts at reset value
        write_touch(1'b0);
        test_directed();
        test_random(550, 14, 59);
        write_touch(1'b1);
        test_random(550, 59, 14);
        write_touch(1'b0);
        test_random(275, 0, 0);
        write_touch(1'b1);
        test_random(275, 0, 0);

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spi_pkg.sv
rtl/segment_pair_intersection.sv
dv/tb_segment_pair_intersection.sv
